[design/bpc_pkg.sv]
`timescale 1ns / 1ps

package bpc_pkg;

  // Buttons and level vector
  localparam int NumButtons = 16;
  localparam int LevelBits  = 16;
  localparam int ScanCount  = (NumButtons < LevelBits) ? NumButtons : LevelBits;
  localparam int IdxW       = 4;
  localparam int CntW       = 16;

  // Tick phases
  localparam logic [2:0] LatchPhase = 3'd5;
  localparam logic [2:0] ScanPhase  = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CfgShort  = 2'd0;
  localparam logic [1:0] CfgMedium = 2'd1;
  localparam logic [1:0] CfgLong   = 2'd2;

  // Threshold reset values
  localparam logic [CntW-1:0] ShortReset  = 16'd4;
  localparam logic [CntW-1:0] MediumReset = 16'd100;
  localparam logic [CntW-1:0] LongReset   = 16'd200;

  typedef enum logic [1:0] {
    KIND_SHORT  = 2'd0,
    KIND_MEDIUM = 2'd1,
    KIND_LONG   = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic            latch;
    logic            step;
    logic            push;
    logic            push_last;
    logic [IdxW-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ev_hit;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

[design/bpc_datapath.sv]
`timescale 1ns / 1ps

module bpc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bpc_pkg::cmd_t            cmd_i,
  output bpc_pkg::status_t         status_o,
  input  logic [15:0]              pin_levels_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [bpc_pkg::IdxW-1:0] button_index_o,
  output logic [1:0]               press_kind_o,
  output logic                     last_event_o
);

  logic [bpc_pkg::CntW-1:0]      short_q, medium_q, long_q;
  logic [bpc_pkg::LevelBits-1:0] lvl_q;
  logic [bpc_pkg::CntW-1:0]      hold_q [bpc_pkg::ScanCount];

  logic                          pend_valid_q;
  logic [bpc_pkg::IdxW-1:0]      pend_idx_q;
  bpc_pkg::kind_e                pend_kind_q;

  logic                          out_valid_q;
  logic [bpc_pkg::IdxW-1:0]      out_idx_q;
  bpc_pkg::kind_e                out_kind_q;
  logic                          out_last_q;

  logic                          pressed;
  logic [bpc_pkg::CntW-1:0]      cnt;
  logic [bpc_pkg::CntW-1:0]      cnt_d;
  logic                          ev_hit;
  bpc_pkg::kind_e                ev_kind;
  logic                          out_free;

  // Per-button update for the button being visited
  always_comb begin
    pressed = ~lvl_q[bpc_pkg::IdxW'(bpc_pkg::LevelBits - 1) - cmd_i.idx];
    cnt     = hold_q[cmd_i.idx];
    cnt_d   = cnt;
    ev_hit  = 1'b0;
    ev_kind = bpc_pkg::KIND_SHORT;
    if (pressed) begin
      if (cnt < short_q) begin
        cnt_d   = cnt + 16'd1;
        ev_hit  = (cnt_d >= short_q);
        ev_kind = bpc_pkg::KIND_SHORT;
      end else if (cnt < long_q) begin
        cnt_d   = cnt + 16'd1;
        ev_hit  = (cnt_d >= long_q);
        ev_kind = bpc_pkg::KIND_LONG;
      end
    end else begin
      cnt_d   = '0;
      ev_hit  = (cnt >= medium_q) && (cnt < long_q);
      ev_kind = bpc_pkg::KIND_MEDIUM;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.ev_hit     = ev_hit;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  // Thresholds, levels, hold counters and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q      <= bpc_pkg::ShortReset;
      medium_q     <= bpc_pkg::MediumReset;
      long_q       <= bpc_pkg::LongReset;
      lvl_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < bpc_pkg::ScanCount; i++) begin
        hold_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bpc_pkg::CfgShort:  short_q  <= cfg_data_i;
          bpc_pkg::CfgMedium: medium_q <= cfg_data_i;
          bpc_pkg::CfgLong:   long_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.latch) begin
        lvl_q <= pin_levels_i;
      end
      if (cmd_i.step) begin
        hold_q[cmd_i.idx] <= cnt_d;
      end
      // one event held back until we know whether it is the last
      if (cmd_i.step && ev_hit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && ev_hit) begin
      pend_idx_q  <= cmd_i.idx;
      pend_kind_q <= ev_kind;
    end
    if (cmd_i.push) begin
      out_idx_q  <= pend_idx_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_index_o = out_idx_q;
  assign press_kind_o   = out_kind_q;
  assign last_event_o   = out_last_q;

  // Only a held event may be moved out, and only into a free slot
  a_push_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (pend_valid_q && out_free))
    else $error("push without a pending event or free output");

  // A new event must never overwrite a pending one
  a_no_pend_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && ev_hit && pend_valid_q) |-> cmd_i.push)
    else $error("pending event overwritten");

endmodule

[design/bpc_ctrl.sv]
`timescale 1ns / 1ps

module bpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bpc_pkg::status_t status_i,
  output bpc_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  logic [2:0]               phase_q, phase_d;
  logic [bpc_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     accept;
  logic                     need_push;
  logic                     last_idx;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign need_push  = status_i.ev_hit && status_i.pend_valid;
  assign last_idx   = (idx_q == bpc_pkg::IdxW'(bpc_pkg::ScanCount - 1));

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    phase_d         = phase_q;
    idx_d           = idx_q;
    cmd_o.latch     = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.push      = 1'b0;
    cmd_o.push_last = 1'b0;
    cmd_o.idx       = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          phase_d = phase_q + 3'd1;
          if (phase_d == bpc_pkg::LatchPhase) begin
            cmd_o.latch = 1'b1;
          end else if (phase_d == bpc_pkg::ScanPhase) begin
            phase_d = '0;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // stall only when the held event must move out and the slot is busy
        if (!need_push || status_i.out_free) begin
          cmd_o.step = 1'b1;
          cmd_o.push = need_push;
          idx_d      = idx_q + bpc_pkg::IdxW'(1);
          if (last_idx) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  // Scan tick starts a walk
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == bpc_pkg::LatchPhase) |=> (state_q == S_SCAN && idx_q == '0))
    else $error("scan did not start on scan tick");

  // Counters only move during a walk
  a_step_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (state_q == S_SCAN))
    else $error("step outside scan");

  // Final marker only on the flush
  a_last_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_last |-> (state_q == S_FLUSH && cmd_o.push))
    else $error("last marker outside flush");

endmodule

[design/button_press_classifier.sv]
`timescale 1ns / 1ps
// Ticks that do not scan are accepted without leaving the idle state.
// A scan tick is accepted, the 16 hold counters are walked in turn, then a flush runs:
//   no tick is taken until the flush ends; walk and flush stall while output is busy.
// An event is held pending and moves out when the next one is found, or in the flush.
// Reset (async, active low) sets thresholds to 4/100/200 and clears all counters.

module button_press_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  button_index_o,
  output logic [1:0]  press_kind_o,
  output logic        last_event_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  bpc_pkg::cmd_t    cmd;
  bpc_pkg::status_t status;

  bpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bpc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pin_levels_i   (pin_levels_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .button_index_o (button_index_o),
    .press_kind_o   (press_kind_o),
    .last_event_o   (last_event_o)
  );

endmodule

[tb/bpc_checker.sv]
`timescale 1ns / 1ps

module bpc_checker
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] pin_levels_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  button_index_i,
  input  logic [1:0]  press_kind_i,
  input  logic        last_event_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [IdxW-1:0] idx;
    kind_e           kind;
    logic            last;
  } press_event_t;

  // Shadow copy of the classifier state
  logic [CntW-1:0]      short_thr;
  logic [CntW-1:0]      medium_thr;
  logic [CntW-1:0]      long_thr;
  logic [2:0]           phase_q;
  logic [LevelBits-1:0] latched_q;
  logic [CntW-1:0]      hold_q [ScanCount];

  press_event_t events_q [$];
  int           fails;

  function automatic press_event_t make_event(input int idx, input kind_e kind);
    press_event_t ev;
    ev.idx  = IdxW'(idx);
    ev.kind = kind;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance the tick phase; latch, or scan all buttons and queue their events
  task automatic classify_tick(input logic [LevelBits-1:0] levels);
    press_event_t    found [$];
    logic [CntW-1:0] cnt;
    logic            pressed;
    phase_q = phase_q + 3'd1;
    if (phase_q == LatchPhase) begin
      latched_q = levels;
    end else if (phase_q > LatchPhase) begin
      phase_q = '0;
      for (int i = 0; i < ScanCount; i++) begin
        pressed = !latched_q[LevelBits-1-i];
        cnt     = hold_q[i];
        if (pressed) begin
          if (cnt < short_thr) begin
            cnt++;
            if (cnt >= short_thr) found.push_back(make_event(i, KIND_SHORT));
          end else if (cnt < long_thr) begin
            cnt++;
            if (cnt >= long_thr) found.push_back(make_event(i, KIND_LONG));
          end
          hold_q[i] = cnt;
        end else begin
          if (cnt >= medium_thr && cnt < long_thr) found.push_back(make_event(i, KIND_MEDIUM));
          hold_q[i] = '0;
        end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) events_q.push_back(found[k]);
    end
  endtask

  // Compare one event transaction against the oldest prediction
  task automatic check_event();
    press_event_t exp_ev;
    logic         bad;
    if (events_q.size() == 0) begin
      $display("%0t: unexpected event: expected none, got button %0d kind %0d last %0d",
               $time, button_index_i, press_kind_i, last_event_i);
      fails++;
    end else begin
      exp_ev = events_q.pop_front();
      bad    = 1'b0;
      if (button_index_i !== exp_ev.idx) begin
        $display("%0t: button_index expected %0d got %0d", $time, exp_ev.idx, button_index_i);
        bad = 1'b1;
      end
      if (press_kind_i !== exp_ev.kind) begin
        $display("%0t: press_kind expected %0d got %0d", $time, exp_ev.kind, press_kind_i);
        bad = 1'b1;
      end
      if (last_event_i !== exp_ev.last) begin
        $display("%0t: last_event expected %0d got %0d", $time, exp_ev.last, last_event_i);
        bad = 1'b1;
      end
      if (bad) fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_thr  = ShortReset;
      medium_thr = MediumReset;
      long_thr   = LongReset;
      phase_q    = '0;
      latched_q  = '0;
      for (int i = 0; i < ScanCount; i++) hold_q[i] = '0;
      events_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes; unknown index is dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgShort:  short_thr  = cfg_data_i;
          CfgMedium: medium_thr = cfg_data_i;
          CfgLong:   long_thr   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) classify_tick(pin_levels_i);
      if (out_valid_i && out_ready_i) check_event();
      fail_count_o <= fails;
      pending_o    <= events_q.size();
    end
  end

endmodule

[tb/tb_button_press_classifier.sv]
`timescale 1ns / 1ps

module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int CycleLimit     = 500000;
  localparam int SettleCycles   = 40;
  localparam int RandomPhases   = 3;
  localparam int RoundsPerPhase = 3;
  localparam logic [1:0] CfgUnused = 2'd3;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic [15:0] pin_levels_i = '0;
  logic        out_ready_i  = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_index_i  = CfgShort;
  logic [15:0] cfg_data_i   = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [3:0]  button_index_o;
  logic [1:0]  press_kind_o;
  logic        last_event_o;

  int          fail_count;
  int          pending;
  int          cycles  = 0;
  logic        no_idle = 1'b0;
  logic [15:0] held_levels;
  logic [15:0] round_levels;

  always #2 clk_i = ~clk_i;

  button_press_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pin_levels_i   (pin_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_o (button_index_o),
    .press_kind_o   (press_kind_o),
    .last_event_o   (last_event_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  bpc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .pin_levels_i   (pin_levels_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_index_i (button_index_o),
    .press_kind_i   (press_kind_o),
    .last_event_i   (last_event_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Event side back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 35);
  end

  // One tick transaction, with a random gap in front
  task automatic send_tick(input logic [15:0] levels);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= levels;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Six ticks: four idle ticks, the latch tick, then the scan tick
  task automatic send_round(input logic [15:0] levels);
    repeat (4) send_tick(16'($urandom));
    send_tick(levels);
    send_tick(16'($urandom));
  endtask

  // Stop sending until every predicted event is out and the scan has finished
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
  endtask

  task automatic set_thresholds(input logic [15:0] s, input logic [15:0] m,
                                input logic [15:0] l);
    settle();
    write_reg(CfgUnused, 16'($urandom));
    write_reg(CfgShort, s);
    write_reg(CfgMedium, m);
    write_reg(CfgLong, l);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small thresholds, now and then an extreme
  function automatic logic [15:0] pick_threshold(input int lo, input int hi);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'hFFFF;
    if (sel == 1) return 16'h0000;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Buttons tend to stay put; each flips now and then
  function automatic logic [15:0] drift_levels(input logic [15:0] prev);
    logic [15:0] lv;
    lv = prev;
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(5) == 0) lv[i] = ~lv[i];
    end
    return lv;
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: all buttons reach a short press, release below medium
    repeat (4) send_round(16'h0000);
    send_round(16'hFFFF);

    // 1/2/3: short, medium on release, long at full count
    set_thresholds(16'd1, 16'd2, 16'd3);
    send_round(16'hAAAA);
    send_round(16'h5555);
    send_round(16'h5555);
    send_round(16'hFFFF);
    repeat (3) send_round(16'h0000);
    send_round(16'hFFFF);

    // zero short threshold: no short events, straight to long
    set_thresholds(16'd0, 16'd1, 16'd2);
    send_round(16'h00FF);
    send_round(16'h0F0F);
    send_round(16'hFFFF);

    // long at or below short: counter parks after the short event
    set_thresholds(16'd3, 16'd1, 16'd2);
    repeat (4) send_round(16'h0000);
    send_round(16'hFFFF);

    // random phases of held and noisy button patterns
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) set_thresholds(16'hFFFF, 16'd1, 16'hFFFF);
      else set_thresholds(pick_threshold(0, 4), pick_threshold(1, 8), pick_threshold(0, 12));
      no_idle     <= (p == 2);
      held_levels = 16'hFFFF;
      for (int r = 0; r < RoundsPerPhase; r++) begin
        if (p == 1 && r == RoundsPerPhase / 2) settle();
        if ($urandom_range(99) < 15) round_levels = 16'($urandom);
        else round_levels = drift_levels(held_levels);
        held_levels = round_levels;
        send_round(round_levels);
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[button_press_classifier.f]
design/bpc_pkg.sv
design/bpc_datapath.sv
design/bpc_ctrl.sv
design/button_press_classifier.sv
tb/bpc_checker.sv
tb/tb_button_press_classifier.sv
